// ===== design/lprc_pkg.sv =====
// ----------------------------------------------------------------------------
// lprc_pkg: shared types and constants
// Configuration register indexes, reset values and the structs passed
// between the calibrator's modules.
// ----------------------------------------------------------------------------
package lprc_pkg;

    localparam int LEVEL_W = 10;
    localparam int TICKS_W = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;

    localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 10'd300;
    localparam logic [TICKS_W-1:0] HOLD_TICKS_RST = 4'd10;
    localparam logic [TICKS_W-1:0] RELEASE_TICKS_RST = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LEVEL   = 2'd0,
        CFG_HOLD_TICKS    = 2'd1,
        CFG_RELEASE_TICKS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_level;
        logic [TICKS_W-1:0] hold_ticks;
        logic [TICKS_W-1:0] release_ticks;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_level;
        logic               led_on;
        logic               ramping;
        logic               stored_now;
        logic [LEVEL_W-1:0] calibrated_level;
    } result_t;

endpackage

// ===== design/lprc_cfg.sv =====
// ----------------------------------------------------------------------------
// lprc_cfg: configuration register file
// Holds start level, hold ticks and release ticks; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module lprc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lprc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lprc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lprc_pkg::cfg_t                    cfg
);

    lprc_pkg::cfg_t cfg_reg;
    lprc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lprc_pkg::CFG_START_LEVEL:
                    cfg_next.start_level = cfg_data[lprc_pkg::LEVEL_W-1:0];
                lprc_pkg::CFG_HOLD_TICKS:
                    cfg_next.hold_ticks = cfg_data[lprc_pkg::TICKS_W-1:0];
                lprc_pkg::CFG_RELEASE_TICKS:
                    cfg_next.release_ticks = cfg_data[lprc_pkg::TICKS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level   <= lprc_pkg::START_LEVEL_RST;
            cfg_reg.hold_ticks    <= lprc_pkg::HOLD_TICKS_RST;
            cfg_reg.release_ticks <= lprc_pkg::RELEASE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/lprc_step.sv =====
// ----------------------------------------------------------------------------
// lprc_step: per-tick control state and result logic
// Press/release counters, command latch, ramp counter and stored level;
// updated once per item when fire is high.
// ----------------------------------------------------------------------------
module lprc_step #(
    parameter int RAMP_END = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lprc_pkg::cfg_t      cfg,
    input  logic                button_pressed,
    input  logic                trigger_high,
    output lprc_pkg::result_t   res
);

    localparam int RW = $clog2(RAMP_END + 1);
    localparam int CW = (RW > 11) ? RW : 11;
    localparam logic [CW-1:0] END_C = CW'(RAMP_END);
    localparam logic [CW-1:0] MAX_C = CW'(lprc_pkg::LEVEL_MAX);
    localparam int CNT_W = lprc_pkg::COUNT_W;
    localparam int LW = lprc_pkg::LEVEL_W;

    logic [CNT_W-1:0] hold_count_reg, hold_count_next;
    logic [CNT_W-1:0] release_count_reg, release_count_next;
    logic             latched_reg, latched_next;
    logic             in_ramp_reg, in_ramp_next;
    logic [RW-1:0]    ramp_value_reg, ramp_value_next;
    logic [LW-1:0]    stored_level_reg, stored_level_next;

    logic [CW-1:0]    start_ext;
    logic             start_past_end;
    logic [RW-1:0]    step_base;
    logic [RW-1:0]    step_value;
    logic [CW-1:0]    base_ext;
    logic [CW-1:0]    value_ext;
    logic             ramp_done;
    logic [LW-1:0]    ramp_pwm;
    logic [LW-1:0]    ramp_store;
    logic [CNT_W-1:0] hold_inc;
    logic [CNT_W-1:0] release_inc;
    logic [CNT_W-1:0] hold_lim;
    logic [CNT_W-1:0] release_lim;

    // one shared ramp increment: continue the ramp, or take its first step
    assign start_ext      = CW'(cfg.start_level);
    assign start_past_end = (start_ext >= END_C);
    assign step_base      = in_ramp_reg ? ramp_value_reg : RW'(start_ext);
    assign step_value     = step_base + RW'(1);
    assign base_ext       = CW'(step_base);
    assign value_ext      = CW'(step_value);
    assign ramp_done      = !trigger_high || (value_ext >= END_C);
    assign ramp_pwm       = (value_ext > MAX_C) ? lprc_pkg::LEVEL_MAX : value_ext[LW-1:0];
    assign ramp_store     = (base_ext > MAX_C) ? lprc_pkg::LEVEL_MAX : base_ext[LW-1:0];

    assign hold_inc    = hold_count_reg + CNT_W'(1);
    assign release_inc = release_count_reg + CNT_W'(1);
    assign hold_lim    = CNT_W'(cfg.hold_ticks);
    assign release_lim = CNT_W'(cfg.release_ticks);

    always_comb
    begin
        hold_count_next    = hold_count_reg;
        release_count_next = release_count_reg;
        latched_next       = latched_reg;
        in_ramp_next       = in_ramp_reg;
        ramp_value_next    = ramp_value_reg;
        stored_level_next  = stored_level_reg;
        res.pwm_level      = stored_level_reg;
        res.led_on         = 1'b0;
        res.ramping        = 1'b0;
        res.stored_now     = 1'b0;

        if (in_ramp_reg)
        begin
            // button is ignored while the ramp runs
            res.pwm_level   = ramp_pwm;
            res.ramping     = 1'b1;
            ramp_value_next = step_value;
            if (ramp_done)
            begin
                stored_level_next = ramp_store;
                in_ramp_next      = 1'b0;
                res.stored_now    = 1'b1;
            end
        end
        else
        begin
            if (button_pressed)
            begin
                hold_count_next = hold_inc;
                if (hold_inc > hold_lim)
                begin
                    latched_next    = 1'b1;
                    hold_count_next = hold_lim;
                end
            end
            else if (hold_count_reg < hold_lim)
            begin
                latched_next    = 1'b0;
                hold_count_next = '0;
            end

            res.led_on = button_pressed && !latched_next;

            if (latched_next)
            begin
                if (button_pressed)
                begin
                    release_count_next = '0;
                end
                else
                begin
                    release_count_next = release_inc;
                    if (release_inc > release_lim)
                    begin
                        latched_next       = 1'b0;
                        hold_count_next    = '0;
                        release_count_next = '0;
                        if (start_past_end)
                        begin
                            stored_level_next = cfg.start_level - LW'(1);
                            res.stored_now    = 1'b1;
                        end
                        else
                        begin
                            res.pwm_level   = ramp_pwm;
                            res.ramping     = 1'b1;
                            ramp_value_next = step_value;
                            if (ramp_done)
                            begin
                                stored_level_next = ramp_store;
                                res.stored_now    = 1'b1;
                            end
                            else
                            begin
                                in_ramp_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        res.calibrated_level = stored_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg    <= '0;
            release_count_reg <= '0;
            latched_reg       <= 1'b0;
            in_ramp_reg       <= 1'b0;
            ramp_value_reg    <= '0;
            stored_level_reg  <= '0;
        end
        else if (fire)
        begin
            hold_count_reg    <= hold_count_next;
            release_count_reg <= release_count_next;
            latched_reg       <= latched_next;
            in_ramp_reg       <= in_ramp_next;
            ramp_value_reg    <= ramp_value_next;
            stored_level_reg  <= stored_level_next;
        end
    end

endmodule

// ===== design/long_press_ramp_calibrator.sv =====
// ----------------------------------------------------------------------------
// long_press_ramp_calibrator: long-press triggered PWM ramp calibration
// An accepted input is held in the input register, then moves into the result
// register, which raises out_valid. Throughput: one item per cycle while
// out_stall is low. Reset: asynchronous, active low; counters, latch and
// stored level clear, registers return to start 300, hold 10, release 3.
// ----------------------------------------------------------------------------
module long_press_ramp_calibrator #(
    parameter int RAMP_END = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              button_pressed,
    input  logic                              trigger_high,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lprc_pkg::LEVEL_W-1:0]      pwm_level,
    output logic                              led_on,
    output logic                              ramping,
    output logic                              stored_now,
    output logic [lprc_pkg::LEVEL_W-1:0]      calibrated_level,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lprc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lprc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lprc_pkg::cfg_t    cfg;
    lprc_pkg::result_t step_res;
    lprc_pkg::result_t res_reg;

    logic in_valid_reg;
    logic button_reg;
    logic trigger_reg;
    logic out_valid_reg;
    logic advance;
    logic in_accept;

    // move the held item into the result register when that slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    lprc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lprc_step #(
        .RAMP_END (RAMP_END)
    ) u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .cfg            (cfg),
        .button_pressed (button_reg),
        .trigger_high   (trigger_reg),
        .res            (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            button_reg  <= button_pressed;
            trigger_reg <= trigger_high;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pwm_level        = res_reg.pwm_level;
    assign led_on           = res_reg.led_on;
    assign ramping          = res_reg.ramping;
    assign stored_now       = res_reg.stored_now;
    assign calibrated_level = res_reg.calibrated_level;

endmodule
